FILE: rtl/core/tzr_pkg.sv
`timescale 1ns / 1ps
package tzr_pkg;

   localparam int COORD_W = 12;
   localparam int VAL_W   = 17;
   localparam int ADDR_W  = 16;
   localparam int DEPTH_W = 16;
   localparam int COLOR_W = 24;
   localparam int COUNT_W = 17;

   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_DRAW   = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 17'd65536;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_READ_DATA, ST_SORT, ST_PHASE, ST_COL,
      ST_COL_START, ST_COL_WAIT, ST_SPAN, ST_PIX_START, ST_PIX_WAIT, ST_PIX_CMP,
      ST_NEXT_COL, ST_DONE
   } tzr_state_type;

   typedef enum logic [1:0] {DV_IDLE, DV_MUL, DV_DIV} tzr_div_state_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [DEPTH_W-1:0] z;
   } tzr_vertex_type;

   typedef struct packed {
      logic [COORD_W-1:0] loc;
      logic [COORD_W-1:0] ls;
      logic [COORD_W-1:0] le;
      logic [VAL_W-1:0]   vs;
      logic [VAL_W-1:0]   ve;
   } tzr_interp_arg_type;

   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      logic [DEPTH_W-1:0] depth;
      logic [COLOR_W-1:0] color;
   } tzr_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } tzr_rd_type;

endpackage

FILE: rtl/core/tzr_interp.sv
`timescale 1ns / 1ps
module tzr_interp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  tzr_pkg::tzr_interp_arg_type         arg,
   output logic                                busy,
   output logic                                done,
   output logic signed [tzr_pkg::VAL_W-1:0]    result
);
   localparam int CW     = tzr_pkg::COORD_W;
   localparam int VW     = tzr_pkg::VAL_W;
   localparam int PROD_W = CW + VW;
   localparam int STEP_W = $clog2(PROD_W + 1);

   tzr_pkg::tzr_div_state_type state_ff, state_in;
   logic [CW-1:0]     n_ff, n_in, dist_ff, dist_in, rem_ff, rem_in;
   logic [VW-1:0]     dmag_ff, dmag_in, quo_ff, quo_in, vs_ff, vs_in, res_ff, res_in;
   logic              neg_ff, neg_in, done_ff, done_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic signed [CW:0] pos_diff, span_diff;
   logic signed [VW:0] val_diff, q_signed, sum;
   logic [CW:0]        rem_try;
   logic [VW-1:0]      q_next;
   logic               q_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tzr_pkg::DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      n_ff    <= n_in;
      dist_ff <= dist_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      quo_ff  <= quo_in;
      vs_ff   <= vs_in;
      res_ff  <= res_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      step_ff <= step_in;
   end

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      dist_in  = dist_ff;
      rem_in   = rem_ff;
      dmag_in  = dmag_ff;
      quo_in   = quo_ff;
      vs_in    = vs_ff;
      res_in   = res_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      step_in  = step_ff;
      done_in  = 1'b0;

      pos_diff  = (CW+1)'($signed(arg.loc)) - (CW+1)'($signed(arg.ls));
      span_diff = (CW+1)'($signed(arg.le)) - (CW+1)'($signed(arg.ls));
      val_diff  = (VW+1)'($signed(arg.ve)) - (VW+1)'($signed(arg.vs));

      rem_try  = {rem_ff, prod_ff[PROD_W-1]};
      q_bit    = (rem_try >= {1'b0, dist_ff});
      q_next   = {quo_ff[VW-2:0], q_bit};
      q_signed = neg_ff ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
      sum      = $signed({vs_ff[VW-1], vs_ff}) + q_signed;

      case (state_ff)
         tzr_pkg::DV_IDLE: begin
            if (start) begin
               n_in    = pos_diff[CW-1:0];
               dist_in = span_diff[CW] ? CW'(-span_diff) : span_diff[CW-1:0];
               dmag_in = val_diff[VW] ? VW'(-val_diff) : val_diff[VW-1:0];
               neg_in  = val_diff[VW];
               vs_in   = arg.vs;
               if (span_diff == '0) begin
                  res_in  = arg.vs;
                  done_in = 1'b1;
               end else begin
                  state_in = tzr_pkg::DV_MUL;
               end
            end
         end
         tzr_pkg::DV_MUL: begin
            prod_in  = PROD_W'(n_ff) * PROD_W'(dmag_ff);
            rem_in   = '0;
            quo_in   = '0;
            step_in  = STEP_W'(PROD_W);
            state_in = tzr_pkg::DV_DIV;
         end
         tzr_pkg::DV_DIV: begin
            rem_in  = q_bit ? CW'(rem_try - {1'b0, dist_ff}) : rem_try[CW-1:0];
            quo_in  = q_next;
            prod_in = {prod_ff[PROD_W-2:0], 1'b0};
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               res_in   = sum[VW-1:0];
               done_in  = 1'b1;
               state_in = tzr_pkg::DV_IDLE;
            end
         end
         default: state_in = tzr_pkg::DV_IDLE;
      endcase
   end

   assign busy   = (state_ff != tzr_pkg::DV_IDLE);
   assign done   = done_ff;
   assign result = $signed(res_ff);

endmodule

FILE: rtl/core/tzr_store.sv
`timescale 1ns / 1ps
module tzr_store (
   input  logic                          clock,
   input  tzr_pkg::tzr_wr_type           wr,
   input  tzr_pkg::tzr_rd_type           rd,
   output logic [tzr_pkg::DEPTH_W-1:0]   rd_depth,
   output logic [tzr_pkg::COLOR_W-1:0]   rd_color
);
   localparam int ENTRIES = 2 ** tzr_pkg::ADDR_W;

   logic [tzr_pkg::DEPTH_W-1:0] depth_mem [ENTRIES];
   logic [tzr_pkg::COLOR_W-1:0] color_mem [ENTRIES];
   logic [tzr_pkg::DEPTH_W-1:0] rd_depth_ff;
   logic [tzr_pkg::COLOR_W-1:0] rd_color_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         depth_mem[wr.addr] <= wr.depth;
         color_mem[wr.addr] <= wr.color;
      end
      if (rd.en) begin
         rd_depth_ff <= depth_mem[rd.addr];
         rd_color_ff <= color_mem[rd.addr];
      end
   end

   assign rd_depth = rd_depth_ff;
   assign rd_color = rd_color_ff;

endmodule

FILE: rtl/core/triangle_zbuffer_rasterizer.sv
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// req       req_valid/req_ready   action, vertices a b c, tri_color, pixel_index
// rsp       rsp_valid/rsp_ready   pixels_written, read_depth, read_color
//
// One item at a time. Clear sweeps the 65536-entry stores, one entry a cycle;
// the same clearing pass runs after reset with req_ready low.
// Read issues the store read, captures its data, then fills the output register.
// Draw runs the shared interpolation divider (one quotient bit a cycle) for
// each visible column and covered pixel, with a registered store read before each depth test.
// The result sits in an output register; a new item is taken while it waits.
module triangle_zbuffer_rasterizer #(
   parameter int XSIZE = 256,
   parameter int YSIZE = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic signed [10:0] req_ax,
   input  logic signed [10:0] req_ay,
   input  logic [15:0]        req_az,
   input  logic signed [10:0] req_bx,
   input  logic signed [10:0] req_by,
   input  logic [15:0]        req_bz,
   input  logic signed [10:0] req_cx,
   input  logic signed [10:0] req_cy,
   input  logic [15:0]        req_cz,
   input  logic [23:0]        req_tri_color,
   input  logic [15:0]        req_pixel_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [16:0]        rsp_pixels_written,
   output logic [15:0]        rsp_read_depth,
   output logic [23:0]        rsp_read_color
);
   localparam int CW   = tzr_pkg::COORD_W;
   localparam int VW   = tzr_pkg::VAL_W;
   localparam int AW   = tzr_pkg::ADDR_W;
   localparam int HX   = XSIZE / 2;
   localparam int HY   = YSIZE / 2;
   localparam int Y_LO = 1 - HY;
   localparam int Y_HI = HY - 1;

   tzr_pkg::tzr_state_type state_ff, state_in;
   tzr_pkg::tzr_vertex_type v_ff [3];
   tzr_pkg::tzr_vertex_type v_in [3];
   tzr_pkg::tzr_vertex_type s [3];
   tzr_pkg::tzr_vertex_type t, va, vb;
   tzr_pkg::tzr_interp_arg_type ip_arg;
   tzr_pkg::tzr_wr_type wr;
   tzr_pkg::tzr_rd_type rd;

   logic [AW-1:0]  clr_idx_ff, clr_idx_in, pix_idx_ff, pix_idx_in;
   logic           clr_rsp_ff, clr_rsp_in, phase_ff, phase_in;
   logic [23:0]    color_ff, color_in;
   logic [CW-1:0]  x_ff, x_in, y_ff, y_in, hi_ff, hi_in, ys_ff, ys_in, ye_ff, ye_in;
   logic [VW-1:0]  zs_ff, zs_in, ze_ff, ze_in, z_ff, z_in;
   logic [1:0]     k_ff, k_in;
   logic [16:0]    count_ff, count_in, out_pw_ff, out_pw_in;
   logic [15:0]    rdep_ff, rdep_in, out_dep_ff, out_dep_in;
   logic [23:0]    rcol_ff, rcol_in, out_col_ff, out_col_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic           ip_start, ip_busy, ip_done;
   logic signed [VW-1:0] ip_res;
   logic [15:0]    st_depth;
   logic [23:0]    st_color;
   logic [CW-1:0]  sw_ys, sw_ye, lo_c, hi_c, last_x;
   logic [VW-1:0]  sw_zs, sw_ze;
   logic [AW-1:0]  pix_addr;
   logic           x_visible;

   tzr_interp u_interp (
      .clock  (clock),
      .reset  (reset),
      .start  (ip_start),
      .arg    (ip_arg),
      .busy   (ip_busy),
      .done   (ip_done),
      .result (ip_res)
   );

   tzr_store u_store (
      .clock    (clock),
      .wr       (wr),
      .rd       (rd),
      .rd_depth (st_depth),
      .rd_color (st_color)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tzr_pkg::ST_CLEAR;
         clr_idx_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      v_ff       <= v_in;
      pix_idx_ff <= pix_idx_in;
      phase_ff   <= phase_in;
      color_ff   <= color_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      hi_ff      <= hi_in;
      ys_ff      <= ys_in;
      ye_ff      <= ye_in;
      zs_ff      <= zs_in;
      ze_ff      <= ze_in;
      z_ff       <= z_in;
      k_ff       <= k_in;
      rdep_ff    <= rdep_in;
      rcol_ff    <= rcol_in;
      out_pw_ff  <= out_pw_in;
      out_dep_ff <= out_dep_in;
      out_col_ff <= out_col_in;
   end

   // exchange sort on column
   always_comb begin
      s = v_ff;
      t = v_ff[0];
      if ($signed(s[0].x) > $signed(s[1].x)) begin
         t = s[0]; s[0] = s[1]; s[1] = t;
      end
      if ($signed(s[0].x) > $signed(s[2].x)) begin
         t = s[0]; s[0] = s[2]; s[2] = t;
      end
      if ($signed(s[1].x) > $signed(s[2].x)) begin
         t = s[1]; s[1] = s[2]; s[2] = t;
      end
   end

   always_comb begin
      va     = phase_ff ? v_ff[1] : v_ff[0];
      vb     = phase_ff ? v_ff[2] : v_ff[1];
      last_x = phase_ff ? v_ff[2].x : v_ff[1].x;
      x_visible = ($signed(x_ff) > -HX) && ($signed(x_ff) < HX);

      // order the span low to high, then clip to the screen
      if ($signed(ys_ff) > $signed(ye_ff)) begin
         sw_ys = ye_ff; sw_ye = ys_ff; sw_zs = ze_ff; sw_ze = zs_ff;
      end else begin
         sw_ys = ys_ff; sw_ye = ye_ff; sw_zs = zs_ff; sw_ze = ze_ff;
      end
      lo_c = ($signed(sw_ys) > Y_LO) ? sw_ys : CW'(Y_LO);
      hi_c = ($signed(sw_ye) < Y_HI) ? sw_ye : CW'(Y_HI);

      pix_addr = AW'(($signed(x_ff) + HX) * YSIZE + $signed(y_ff) + HY);

      ip_arg = '0;
      if (state_ff == tzr_pkg::ST_PIX_START) begin
         ip_arg.loc = y_ff;
         ip_arg.ls  = ys_ff;
         ip_arg.le  = ye_ff;
         ip_arg.vs  = zs_ff;
         ip_arg.ve  = ze_ff;
      end else begin
         ip_arg.loc = x_ff;
         case (k_ff)
            2'd0: begin
               ip_arg.ls = va.x; ip_arg.le = vb.x;
               ip_arg.vs = VW'($signed(va.y)); ip_arg.ve = VW'($signed(vb.y));
            end
            2'd1: begin
               ip_arg.ls = v_ff[0].x; ip_arg.le = v_ff[2].x;
               ip_arg.vs = VW'($signed(v_ff[0].y)); ip_arg.ve = VW'($signed(v_ff[2].y));
            end
            2'd2: begin
               ip_arg.ls = va.x; ip_arg.le = vb.x;
               ip_arg.vs = {1'b0, va.z}; ip_arg.ve = {1'b0, vb.z};
            end
            default: begin
               ip_arg.ls = v_ff[0].x; ip_arg.le = v_ff[2].x;
               ip_arg.vs = {1'b0, v_ff[0].z}; ip_arg.ve = {1'b0, v_ff[2].z};
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      clr_rsp_in   = clr_rsp_ff;
      v_in         = v_ff;
      pix_idx_in   = pix_idx_ff;
      phase_in     = phase_ff;
      color_in     = color_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      hi_in        = hi_ff;
      ys_in        = ys_ff;
      ye_in        = ye_ff;
      zs_in        = zs_ff;
      ze_in        = ze_ff;
      z_in         = z_ff;
      k_in         = k_ff;
      count_in     = count_ff;
      rdep_in      = rdep_ff;
      rcol_in      = rcol_ff;
      out_pw_in    = out_pw_ff;
      out_dep_in   = out_dep_ff;
      out_col_in   = out_col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      ip_start     = 1'b0;
      wr           = '0;
      rd           = '0;

      case (state_ff)
         tzr_pkg::ST_CLEAR: begin
            wr.en      = 1'b1;
            wr.addr    = clr_idx_ff;
            wr.depth   = tzr_pkg::DEPTH_MAX;
            wr.color   = '0;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (&clr_idx_ff) begin
               state_in = clr_rsp_ff ? tzr_pkg::ST_DONE : tzr_pkg::ST_IDLE;
            end
         end
         tzr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               v_in[0]    = '{x: CW'(req_ax), y: CW'(req_ay), z: req_az};
               v_in[1]    = '{x: CW'(req_bx), y: CW'(req_by), z: req_bz};
               v_in[2]    = '{x: CW'(req_cx), y: CW'(req_cy), z: req_cz};
               color_in   = req_tri_color;
               pix_idx_in = req_pixel_index;
               count_in   = '0;
               rdep_in    = '0;
               rcol_in    = '0;
               case (req_action)
                  tzr_pkg::ACT_CLEAR: begin
                     clr_rsp_in = 1'b1;
                     clr_idx_in = '0;
                     state_in   = tzr_pkg::ST_CLEAR;
                  end
                  tzr_pkg::ACT_DRAW: state_in = tzr_pkg::ST_SORT;
                  tzr_pkg::ACT_READ: state_in = tzr_pkg::ST_READ;
                  default:           state_in = tzr_pkg::ST_DONE;
               endcase
            end
         end
         tzr_pkg::ST_READ: begin
            rd.en    = 1'b1;
            rd.addr  = pix_idx_ff;
            state_in = tzr_pkg::ST_READ_DATA;
         end
         tzr_pkg::ST_READ_DATA: begin
            rdep_in  = st_depth;
            rcol_in  = st_color;
            state_in = tzr_pkg::ST_DONE;
         end
         tzr_pkg::ST_SORT: begin
            v_in     = s;
            phase_in = 1'b0;
            state_in = tzr_pkg::ST_PHASE;
         end
         tzr_pkg::ST_PHASE: begin
            if (!phase_ff) begin
               if (v_ff[0].x != v_ff[1].x) begin
                  x_in     = v_ff[0].x;
                  state_in = tzr_pkg::ST_COL;
               end else begin
                  phase_in = 1'b1;
               end
            end else if (v_ff[1].x != v_ff[2].x) begin
               x_in     = v_ff[1].x + 1'b1;
               state_in = tzr_pkg::ST_COL;
            end else begin
               state_in = tzr_pkg::ST_DONE;
            end
         end
         tzr_pkg::ST_COL: begin
            if ($signed(x_ff) > $signed(last_x)) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  state_in = tzr_pkg::ST_PHASE;
               end else begin
                  state_in = tzr_pkg::ST_DONE;
               end
            end else if (x_visible) begin
               k_in     = 2'd0;
               state_in = tzr_pkg::ST_COL_START;
            end else begin
               x_in = x_ff + 1'b1;
            end
         end
         tzr_pkg::ST_COL_START: begin
            ip_start = 1'b1;
            state_in = tzr_pkg::ST_COL_WAIT;
         end
         tzr_pkg::ST_COL_WAIT: begin
            if (ip_done) begin
               case (k_ff)
                  2'd0:    ys_in = ip_res[CW-1:0];
                  2'd1:    ye_in = ip_res[CW-1:0];
                  2'd2:    zs_in = ip_res;
                  default: ze_in = ip_res;
               endcase
               k_in     = k_ff + 1'b1;
               state_in = (k_ff == 2'd3) ? tzr_pkg::ST_SPAN : tzr_pkg::ST_COL_START;
            end
         end
         tzr_pkg::ST_SPAN: begin
            ys_in = sw_ys;
            ye_in = sw_ye;
            zs_in = sw_zs;
            ze_in = sw_ze;
            y_in  = lo_c;
            hi_in = hi_c;
            state_in = ($signed(lo_c) > $signed(hi_c)) ? tzr_pkg::ST_NEXT_COL
                                                       : tzr_pkg::ST_PIX_START;
         end
         tzr_pkg::ST_PIX_START: begin
            ip_start = 1'b1;
            state_in = tzr_pkg::ST_PIX_WAIT;
         end
         tzr_pkg::ST_PIX_WAIT: begin
            if (ip_done) begin
               z_in     = ip_res;
               rd.en    = 1'b1;
               rd.addr  = pix_addr;
               state_in = tzr_pkg::ST_PIX_CMP;
            end
         end
         tzr_pkg::ST_PIX_CMP: begin
            if (z_ff[15:0] < st_depth) begin
               wr.en    = 1'b1;
               wr.addr  = pix_addr;
               wr.depth = z_ff[15:0];
               wr.color = color_ff;
               if (count_ff < tzr_pkg::COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
            end
            if (y_ff == hi_ff) begin
               state_in = tzr_pkg::ST_NEXT_COL;
            end else begin
               y_in     = y_ff + 1'b1;
               state_in = tzr_pkg::ST_PIX_START;
            end
         end
         tzr_pkg::ST_NEXT_COL: begin
            x_in     = x_ff + 1'b1;
            state_in = tzr_pkg::ST_COL;
         end
         tzr_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               out_pw_in    = count_ff;
               out_dep_in   = rdep_ff;
               out_col_in   = rcol_ff;
               rsp_valid_in = 1'b1;
               clr_rsp_in   = 1'b0;
               state_in     = tzr_pkg::ST_IDLE;
            end
         end
         default: state_in = tzr_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixels_written = out_pw_ff;
   assign rsp_read_depth     = out_dep_ff;
   assign rsp_read_color     = out_col_ff;

   a_no_read_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tzr_pkg::ST_CLEAR) |-> !rd.en)
      else $error("store read during clearing pass");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tzr_pkg::COUNT_MAX)
      else $error("write count past saturation");

   a_interp_idle: assert property (@(posedge clock) disable iff (reset)
      ip_start |-> !ip_busy)
      else $error("interpolator started while busy");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != tzr_pkg::ST_IDLE))
      else $error("item accepted without leaving idle");

endmodule
